FILE: hdl/gri_pkg.sv
// package: widths, codes and tables shared by the gear ratio indicator files
`default_nettype none

package gri_pkg;

    localparam int COUNTER_BITS    = 16;
    localparam int AVERAGE_WINDOWS = 4;

    localparam int IN_COUNT_W = 16;
    localparam int CNT_W      = (COUNTER_BITS < IN_COUNT_W) ? COUNTER_BITS : IN_COUNT_W;
    localparam int PROD_W     = CNT_W + 8;
    localparam int NUM_W      = CNT_W + 9;

    localparam int SUM_W       = $clog2(255 * AVERAGE_WINDOWS + 1);
    localparam int AVG_CNT_W   = $clog2(AVERAGE_WINDOWS + 1);
    localparam int AVG_SHIFT   = SUM_W + 3;
    localparam int AVG_MULT_W  = AVG_SHIFT + 1;
    localparam int AVG_PROD_W  = SUM_W + AVG_MULT_W;
    localparam logic [AVG_MULT_W-1:0] AVG_MULT =
        AVG_MULT_W'(((64'd1 << AVG_SHIFT) + AVERAGE_WINDOWS - 1) / AVERAGE_WINDOWS);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int NUM_TH      = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_RATIO_SCALE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TH_TWO      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TH_SIX      = 3'd5;

    localparam logic [7:0] RATIO_SCALE_RST = 8'd70;
    localparam logic [7:0] TH_TWO_RST      = 8'hCE;
    localparam logic [7:0] TH_THREE_RST    = 8'hAB;
    localparam logic [7:0] TH_FOUR_RST     = 8'h92;
    localparam logic [7:0] TH_FIVE_RST     = 8'h80;
    localparam logic [7:0] TH_SIX_RST      = 8'h72;

    localparam logic [7:0] LEVEL_ABORT = 8'hFF;
    localparam logic [7:0] LEVEL_MAX   = 8'hFE;

    localparam logic [3:0] SYM_ZERO  = 4'd0;
    localparam logic [3:0] SYM_N     = 4'd10;
    localparam logic [3:0] SYM_L     = 4'd11;
    localparam logic [3:0] SYM_DASH  = 4'd12;
    localparam logic [3:0] SYM_BLANK = 4'd14;

    localparam logic [3:0] STEP_FIRST   = 4'd1;
    localparam logic [3:0] STEP_SECOND  = 4'd2;
    localparam logic [3:0] STEP_COMPUTE = 4'd7;
    localparam logic [3:0] STEP_IDLE    = 4'd8;
    localparam logic [3:0] STEP_DONE    = 4'd15;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_CHK  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    function automatic logic [6:0] seg_pattern(input logic [3:0] sym);
        logic [6:0] seg;
        begin
            case (sym)
                4'd0:    seg = 7'h3F;
                4'd1:    seg = 7'h06;
                4'd2:    seg = 7'h5B;
                4'd3:    seg = 7'h4F;
                4'd4:    seg = 7'h66;
                4'd5:    seg = 7'h6D;
                4'd6:    seg = 7'h7D;
                4'd7:    seg = 7'h07;
                4'd8:    seg = 7'h7F;
                4'd9:    seg = 7'h67;
                4'd10:   seg = 7'h54;
                4'd11:   seg = 7'h38;
                4'd12:   seg = 7'h40;
                4'd13:   seg = 7'h71;
                default: seg = 7'h00;
            endcase
            return seg;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/gri_channels.sv
// channel interfaces: window request in, display result out
`default_nettype none

interface gri_window_if import gri_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [IN_COUNT_W-1:0] rpm_count;
    logic [IN_COUNT_W-1:0] speed_count;
    logic                  rpm_overflow;
    logic                  speed_overflow;
    logic                  window_aborted;
    logic                  neutral;
    logic                  clutch;
    logic                  setup_switch;

    modport source (
        output valid, rpm_count, speed_count, rpm_overflow, speed_overflow,
               window_aborted, neutral, clutch, setup_switch,
        input  ready
    );
    modport sink (
        input  valid, rpm_count, speed_count, rpm_overflow, speed_overflow,
               window_aborted, neutral, clutch, setup_switch,
        output ready
    );
endinterface

interface gri_result_if import gri_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [3:0] symbol;
    logic [6:0] segments;
    logic       update_display;
    logic [7:0] ratio_level;
    logic       overflow_error;

    modport source (
        output valid, symbol, segments, update_display, ratio_level, overflow_error,
        input  ready
    );
    modport sink (
        input  valid, symbol, segments, update_display, ratio_level, overflow_error,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/gear_ratio_indicator_core.sv
// gear ratio indicator: ratio level, calibration and gear display symbol
// sequence: an accepted window goes through multiply, check, the 8-step restoring divider,
//   accumulate and finish; check skips the divider when the ratio saturates early, and an
//   aborted, overflowed or zero-count window skips check and divider; the divider uses one
//   shared compare/subtract unit; ready only while the sequencer is idle, one window at a time
// reset: control and calibration state cleared, thresholds loaded with their defaults
`default_nettype none

module gear_ratio_indicator_core import gri_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    gri_window_if.sink                  window,
    gri_result_if.source                result,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    state_t state_reg, state_next;

    logic [7:0]       ratio_scale_reg;
    logic [7:0]       thr_reg [NUM_TH];
    logic [3:0]       cal_step_reg;
    logic [7:0]       first_level_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [AVG_CNT_W-1:0] avg_cnt_reg;
    logic             avg_path_reg;

    logic [CNT_W-1:0] rpm_reg;
    logic [CNT_W-1:0] speed_reg;
    logic             rov_reg, sov_reg, aborted_reg;
    logic             neutral_reg, clutch_reg, setup_reg;

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] dsh_reg;
    logic [7:0]       quot_reg;
    logic [2:0]       bit_cnt_reg;
    logic [7:0]       level_reg;

    logic             out_valid_reg;
    logic [3:0]       out_sym_reg;
    logic [6:0]       out_seg_reg;
    logic             out_upd_reg;
    logic [7:0]       out_level_reg;
    logic             out_ovf_reg;

    // shared compare/subtract unit
    logic             div_ge;
    logic [NUM_W-1:0] div_diff;
    logic [7:0]       quot_next;

    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num_init;
    logic              special;
    logic [7:0]        special_level;

    logic [7:0]        mid [NUM_TH];

    logic              out_free;
    logic              avg_full;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [7:0]        avg_val;
    logic [3:0]        cal_fin;
    logic [3:0]        fin_sym;
    logic              fin_upd;
    logic [3:0]        cls_sym;
    logic              cls_upd;

    assign div_ge    = num_reg >= dsh_reg;
    assign div_diff  = num_reg - dsh_reg;
    assign quot_next = {quot_reg[6:0], div_ge};

    assign prod     = PROD_W'(rpm_reg) * PROD_W'(ratio_scale_reg);
    assign num_init = NUM_W'({prod, 1'b0}) + NUM_W'(speed_reg);

    always_comb
    begin
        special       = 1'b1;
        special_level = 8'd0;
        if (aborted_reg)
        begin
            special_level = LEVEL_ABORT;
        end
        else if (rov_reg || sov_reg || (rpm_reg == '0) || (speed_reg == '0))
        begin
            special_level = 8'd0;
        end
        else
        begin
            special = 1'b0;
        end
    end

    // floor midpoints of the raw calibrated levels
    always_comb
    begin
        mid[0] = 8'((9'(first_level_reg) + 9'(thr_reg[0])) >> 1);
        for (int i = 1; i < NUM_TH; i++)
        begin
            mid[i] = 8'((9'(thr_reg[i-1]) + 9'(thr_reg[i])) >> 1);
        end
    end

    assign out_free = !out_valid_reg || result.ready;
    assign avg_full = avg_path_reg && (avg_cnt_reg == AVG_CNT_W'(AVERAGE_WINDOWS));
    assign avg_prod = AVG_PROD_W'(sum_reg) * AVG_PROD_W'(AVG_MULT);
    assign avg_val  = avg_prod[AVG_SHIFT +: 8];

    always_comb
    begin
        cal_fin = cal_step_reg;
        if (avg_full && (cal_step_reg >= STEP_FIRST) && (cal_step_reg < STEP_COMPUTE))
        begin
            cal_fin = cal_step_reg + 4'd1;
        end
    end

    always_comb
    begin
        cls_upd = 1'b1;
        if (level_reg == LEVEL_ABORT)
        begin
            cls_sym = SYM_BLANK;
            cls_upd = 1'b0;
        end
        else if (level_reg == 8'd0)     cls_sym = SYM_ZERO;
        else if (level_reg < thr_reg[4]) cls_sym = 4'd6;
        else if (level_reg < thr_reg[3]) cls_sym = 4'd5;
        else if (level_reg < thr_reg[2]) cls_sym = 4'd4;
        else if (level_reg < thr_reg[1]) cls_sym = 4'd3;
        else if (level_reg < thr_reg[0]) cls_sym = 4'd2;
        else                             cls_sym = 4'd1;
    end

    always_comb
    begin
        fin_upd = 1'b1;
        if (neutral_reg)
        begin
            fin_sym = setup_reg ? SYM_L : SYM_N;
        end
        else if (clutch_reg)
        begin
            fin_sym = SYM_DASH;
        end
        else if (setup_reg && (cal_fin != STEP_DONE))
        begin
            fin_sym = cal_fin;
        end
        else
        begin
            fin_sym = cls_sym;
            fin_upd = cls_upd;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (window.valid) state_next = ST_MUL;
            ST_MUL:  state_next = special ? ST_ACC : ST_CHK;
            ST_CHK:  state_next = div_ge ? ST_ACC : ST_DIV;
            ST_DIV:  if (bit_cnt_reg == 3'd7) state_next = ST_ACC;
            ST_ACC:  state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign window.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath: capture, multiply, divide
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                rpm_reg     <= window.rpm_count[CNT_W-1:0];
                speed_reg   <= window.speed_count[CNT_W-1:0];
                rov_reg     <= window.rpm_overflow;
                sov_reg     <= window.speed_overflow;
                aborted_reg <= window.window_aborted;
                neutral_reg <= window.neutral;
                clutch_reg  <= window.clutch;
                setup_reg   <= window.setup_switch;
            end
            ST_MUL:
            begin
                num_reg   <= num_init;
                dsh_reg   <= NUM_W'({speed_reg, 9'd0});
                level_reg <= special_level;
            end
            ST_CHK:
            begin
                level_reg   <= LEVEL_MAX;
                dsh_reg     <= dsh_reg >> 1;
                bit_cnt_reg <= 3'd0;
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    num_reg <= div_diff;
                end
                dsh_reg     <= dsh_reg >> 1;
                quot_reg    <= quot_next;
                bit_cnt_reg <= bit_cnt_reg + 3'd1;
                level_reg   <= (quot_next == LEVEL_ABORT) ? LEVEL_MAX : quot_next;
            end
            default:
            begin
            end
        endcase
    end

    // configuration and calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_scale_reg <= RATIO_SCALE_RST;
            thr_reg[0]      <= TH_TWO_RST;
            thr_reg[1]      <= TH_THREE_RST;
            thr_reg[2]      <= TH_FOUR_RST;
            thr_reg[3]      <= TH_FIVE_RST;
            thr_reg[4]      <= TH_SIX_RST;
            cal_step_reg    <= STEP_IDLE;
            first_level_reg <= 8'd0;
            sum_reg         <= '0;
            avg_cnt_reg     <= '0;
            avg_path_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index) inside
                    REG_RATIO_SCALE:          ratio_scale_reg <= cfg_wdata;
                    [REG_TH_TWO:REG_TH_SIX]:  thr_reg[cfg_index - REG_TH_TWO] <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_ACC)
            begin
                avg_path_reg <= 1'b0;
                if (neutral_reg)
                begin
                    if (setup_reg && (cal_step_reg > STEP_SECOND))
                    begin
                        cal_step_reg <= STEP_FIRST;
                    end
                end
                else if (!clutch_reg && setup_reg)
                begin
                    if (cal_step_reg < STEP_COMPUTE)
                    begin
                        avg_path_reg <= 1'b1;
                    end
                    else if (cal_step_reg == STEP_COMPUTE)
                    begin
                        for (int i = 0; i < NUM_TH; i++)
                        begin
                            thr_reg[i] <= mid[i];
                        end
                        cal_step_reg <= STEP_DONE;
                    end
                end

                if (!neutral_reg && !clutch_reg && setup_reg && (cal_step_reg < STEP_COMPUTE))
                begin
                    sum_reg     <= sum_reg + SUM_W'(level_reg);
                    avg_cnt_reg <= avg_cnt_reg + AVG_CNT_W'(1);
                end
                else
                begin
                    sum_reg     <= '0;
                    avg_cnt_reg <= '0;
                end
            end

            if ((state_reg == ST_FIN) && out_free && avg_full)
            begin
                if (cal_step_reg == STEP_FIRST)
                begin
                    first_level_reg <= avg_val;
                end
                else if ((cal_step_reg >= STEP_SECOND) && (cal_step_reg < STEP_COMPUTE))
                begin
                    thr_reg[3'(cal_step_reg - STEP_SECOND)] <= avg_val;
                end
                cal_step_reg <= cal_fin;
                sum_reg      <= '0;
                avg_cnt_reg  <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FIN) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_sym_reg   <= fin_sym;
            out_seg_reg   <= fin_upd ? seg_pattern(fin_sym) : 7'd0;
            out_upd_reg   <= fin_upd;
            out_level_reg <= level_reg;
            out_ovf_reg   <= (rov_reg || sov_reg) && !aborted_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.symbol         = out_sym_reg;
    assign result.segments       = out_seg_reg;
    assign result.update_display = out_upd_reg;
    assign result.ratio_level    = out_level_reg;
    assign result.overflow_error = out_ovf_reg;

    a_blank_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.update_display
            |-> (result.symbol == SYM_BLANK) && (result.segments == 7'd0))
        else $error("held display result is not blank");

    a_overflow_level: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.overflow_error |-> (result.ratio_level == 8'd0))
        else $error("overflow window with nonzero level");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        window.valid && window.ready |=> !window.ready)
        else $error("ready right after an accepted window");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && (bit_cnt_reg != 3'd7) |=> (state_reg == ST_DIV))
        else $error("divider left before all quotient bits");

endmodule

`default_nettype wire
